@@ src/wsu_pkg.sv @@
// Shared types and codes for the WebSocket text frame unmasker.
// No dependencies; every other file in src imports this package.
package wsu_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 3;
	localparam int unsigned LenW = 16;
	localparam int unsigned KeyBytes = 4;
	localparam int unsigned KeyIdxW = $clog2(KeyBytes);

	localparam logic [3:0] OpText = 4'h1;
	localparam logic [6:0] Len7Ext16 = 7'd126;
	localparam logic [6:0] Len7Ext64 = 7'd127;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HDR     = 3'd1,
		PH_LEN_HI  = 3'd2,
		PH_LEN_LO  = 3'd3,
		PH_KEY     = 3'd4,
		PH_PAYLOAD = 3'd5
	} phase_t;

	typedef enum logic [KindW-1:0] {
		KIND_DATA     = 3'd0,
		KIND_EMPTY    = 3'd1,
		KIND_BAD_OP   = 3'd2,
		KIND_UNMASKED = 3'd3,
		KIND_LEN64    = 3'd4
	} kind_t;

	// One result as it leaves the parser toward the output register.
	typedef struct packed {
		logic             valid;
		logic [ByteW-1:0] data;
		kind_t            kind;
		logic             last;
	} result_t;

endpackage

@@ src/wsu_parser.sv @@
// Frame parser: phase, length, mask key and key position registers plus the
// per-byte decode and unmask logic. Depends on wsu_pkg.
module wsu_parser import wsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             frame_start,
	input  logic [ByteW-1:0] data_byte,
	output result_t          result,
	output phase_t           phase
);

	phase_t                          phase_q, phase_d;
	logic [LenW-1:0]                 remaining_q, remaining_d;
	logic [KeyBytes-1:0][ByteW-1:0]  key_q, key_d;
	logic [KeyIdxW-1:0]              key_idx_q, key_idx_d;
	logic [LenW-1:0]                 remaining_dec;

	assign phase = phase_q;
	assign remaining_dec = remaining_q - LenW'(1);

	always_comb begin
		phase_d = phase_q;
		remaining_d = remaining_q;
		key_d = key_q;
		key_idx_d = key_idx_q;
		result = '{valid: 1'b0, data: '0, kind: KIND_DATA, last: 1'b0};

		if (frame_start) begin
			// A frame start always restarts the parser, even mid-frame.
			if (data_byte[3:0] != OpText) begin
				result = '{valid: 1'b1, data: '0, kind: KIND_BAD_OP, last: 1'b1};
				phase_d = PH_IDLE;
			end else begin
				phase_d = PH_HDR;
			end
		end else begin
			unique case (phase_q)
				PH_HDR: begin
					if (!data_byte[7]) begin
						result = '{valid: 1'b1, data: '0, kind: KIND_UNMASKED, last: 1'b1};
						phase_d = PH_IDLE;
					end else if (data_byte[6:0] == Len7Ext64) begin
						result = '{valid: 1'b1, data: '0, kind: KIND_LEN64, last: 1'b1};
						phase_d = PH_IDLE;
					end else if (data_byte[6:0] == Len7Ext16) begin
						phase_d = PH_LEN_HI;
					end else begin
						remaining_d = LenW'(data_byte[6:0]);
						key_idx_d = '0;
						phase_d = PH_KEY;
					end
				end
				PH_LEN_HI: begin
					remaining_d = {data_byte, {(LenW-ByteW){1'b0}}};
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					remaining_d = remaining_q | LenW'(data_byte);
					key_idx_d = '0;
					phase_d = PH_KEY;
				end
				PH_KEY: begin
					key_d[key_idx_q] = data_byte;
					key_idx_d = key_idx_q + KeyIdxW'(1);
					if (key_idx_q == KeyIdxW'(KeyBytes - 1)) begin
						if (remaining_q == '0) begin
							result = '{valid: 1'b1, data: '0, kind: KIND_EMPTY, last: 1'b1};
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					key_idx_d = key_idx_q + KeyIdxW'(1);
					remaining_d = remaining_dec;
					result = '{valid: 1'b1, data: data_byte ^ key_q[key_idx_q],
						kind: KIND_DATA, last: (remaining_dec == '0)};
					if (remaining_dec == '0) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			remaining_q <= '0;
			key_q <= '0;
			key_idx_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			remaining_q <= remaining_d;
			key_q <= key_d;
			key_idx_q <= key_idx_d;
		end
	end

endmodule

@@ src/wsu_out_reg.sv @@
// Result register in front of the output channel; loads when empty or
// when the waiting result is being taken. Depends on wsu_pkg.
module wsu_out_reg import wsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  result_t          result,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [ByteW-1:0] out_byte,
	output logic [KindW-1:0] kind,
	output logic             last
);

	logic             valid_q;
	logic [ByteW-1:0] byte_q;
	kind_t            kind_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= result.valid;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && result.valid) begin
			byte_q <= result.data;
			kind_q <= result.kind;
			last_q <= result.last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign kind = kind_q;
	assign last = last_q;

endmodule

@@ src/websocket_text_frame_unmasker_core.sv @@
// Top level of the WebSocket text frame unmasker: input register, parser and
// result register. Depends on wsu_pkg, wsu_parser and wsu_out_reg.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------
//   in      | in_valid / in_ready  | frame_start, data_byte
//   out     | out_valid / out_ready| out_byte, kind, last
//
// Each byte is captured in the input register on its transfer, decoded and
// unmasked from there, and its result (if any) is loaded into the result
// register when that stage moves on. One byte is taken every cycle while results
// drain. The result register is the only stall point: a held result blocks the
// input register, which in turn drops in_ready.
// Asynchronous reset returns the parser to idle with empty registers.
module websocket_text_frame_unmasker_core import wsu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             frame_start,
	input  logic [ByteW-1:0] data_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ByteW-1:0] out_byte,
	output logic [KindW-1:0] kind,
	output logic             last
);

	logic             valid_s1;
	logic             start_s1;
	logic [ByteW-1:0] byte_s1;
	logic             advance;
	result_t          result;
	phase_t           phase;

	// The stage moves on when the result register is free or being emptied;
	// bytes that give no result move on as well and simply leave it as is.
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			start_s1 <= frame_start;
			byte_s1 <= data_byte;
		end
	end

	wsu_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.frame_start (start_s1),
		.data_byte   (byte_s1),
		.result      (result),
		.phase       (phase)
	);

	wsu_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.kind      (kind),
		.last      (last)
	);

	// Status results always close the frame with a zero byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_DATA) |-> last && (out_byte == '0))
		else $error("status result without last or with nonzero byte");

	// A loaded byte with a free result register never holds the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid |-> in_ready)
		else $error("input stalled while result register empty");

	// A result marked last leaves the parser idle.
	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.valid && result.last |=> phase == PH_IDLE)
		else $error("parser not idle after final result of a frame");

endmodule

@@ dv/tb_websocket_text_frame_unmasker_core.sv @@
// Testbench for websocket_text_frame_unmasker_core: random and directed frame bytes
// with random idle on both channels, checked against an in-bench frame parser.
// Depends on wsu_pkg and the RTL under src.
module tb_websocket_text_frame_unmasker_core;
	import wsu_pkg::*;

	// Upper bound on the whole run, far above what a correct block needs even with
	// every transfer waiting out the longest gap on both sides.
	localparam int unsigned CycleLimit = 600000;
	// Number of parsed (not ignored) input bytes after which the random part stops.
	localparam int unsigned ByteTarget = 1050;
	localparam int unsigned MaxIdle = 17;

	// One expected result of the unmasker.
	typedef struct {
		logic [ByteW-1:0] data;
		kind_t            kind;
		logic             last;
	} unmask_result_t;

	// Frame parser that mirrors the block and keeps the results it has yet to see.
	// take_byte runs on every input transfer; match_result runs on every output
	// transfer and compares against the oldest pending result.
	class frame_unmasker_book;
		phase_t           state;
		logic [LenW-1:0]  bytes_left;
		logic [31:0]      key;
		logic [KeyIdxW-1:0] key_pos;
		unmask_result_t   pending[$];
		int unsigned      mismatches;

		function new();
			state = PH_IDLE;
			bytes_left = '0;
			key = '0;
			key_pos = '0;
			mismatches = 0;
		endfunction

		task report_mismatch(string what);
			$display("MISMATCH: %s", what);
			mismatches++;
		endtask

		function void queue_result(logic [ByteW-1:0] data, kind_t k, logic l);
			unmask_result_t r;
			r.data = data;
			r.kind = k;
			r.last = l;
			pending.push_back(r);
		endfunction

		// Errors end the frame with a zero byte marked last.
		function void abort_frame(kind_t k);
			state = PH_IDLE;
			queue_result('0, k, 1'b1);
		endfunction

		// Returns 1 when the byte is dropped because no frame is open.
		function bit take_byte(logic start, logic [ByteW-1:0] b);
			logic [ByteW-1:0] pad;
			if (start) begin
				if (b[3:0] != OpText)
					abort_frame(KIND_BAD_OP);
				else
					state = PH_HDR;
				return 1'b0;
			end
			case (state)
				PH_IDLE: begin
					return 1'b1;
				end
				PH_HDR: begin
					// The mask bit is judged before the length code.
					if (!b[7])
						abort_frame(KIND_UNMASKED);
					else if (b[6:0] == Len7Ext64)
						abort_frame(KIND_LEN64);
					else if (b[6:0] == Len7Ext16)
						state = PH_LEN_HI;
					else begin
						bytes_left = LenW'(b[6:0]);
						key_pos = '0;
						state = PH_KEY;
					end
				end
				PH_LEN_HI: begin
					bytes_left = {b, 8'h00};
					state = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					bytes_left[7:0] = b;
					key_pos = '0;
					state = PH_KEY;
				end
				PH_KEY: begin
					key[8*key_pos +: 8] = b;
					if (key_pos == KeyIdxW'(KeyBytes - 1)) begin
						key_pos = '0;
						if (bytes_left == '0) begin
							state = PH_IDLE;
							queue_result('0, KIND_EMPTY, 1'b1);
						end else begin
							state = PH_PAYLOAD;
						end
					end else begin
						key_pos++;
					end
				end
				PH_PAYLOAD: begin
					pad = key[8*key_pos +: 8];
					key_pos++;
					bytes_left--;
					if (bytes_left == '0)
						state = PH_IDLE;
					queue_result(b ^ pad, KIND_DATA, bytes_left == '0);
				end
				default: begin
					state = PH_IDLE;
				end
			endcase
			return 1'b0;
		endfunction

		task match_result(logic [ByteW-1:0] data, logic [KindW-1:0] k, logic l);
			unmask_result_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte=%02h kind=%0d last=%0b",
					data, k, l));
				return;
			end
			e = pending.pop_front();
			if (data !== e.data)
				report_mismatch($sformatf("out_byte %02h, expected %02h", data, e.data));
			if (k !== e.kind)
				report_mismatch($sformatf("kind %0d, expected %0d", k, e.kind));
			if (l !== e.last)
				report_mismatch($sformatf("last %0b, expected %0b", l, e.last));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             frame_start = 1'b0;
	logic [ByteW-1:0] data_byte = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [ByteW-1:0] out_byte;
	logic [KindW-1:0] kind;
	logic             last;

	// When set, neither side inserts idle cycles, so the block runs at full rate.
	bit               no_idle = 1'b0;
	int unsigned      parsed_bytes = 0;
	int unsigned      cycle_count = 0;
	frame_unmasker_book book;

	websocket_text_frame_unmasker_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.frame_start(frame_start),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.kind       (kind),
		.last       (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A watchdog on cycles: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("tb_websocket_text_frame_unmasker_core: errors");
			$finish;
		end
	end

	// Every output transfer is checked at the edge where it happens. Outputs are read
	// before this edge's updates land, so the sample is the value that was transferred.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.match_result(out_byte, kind, last);
	end

	// Result side: before each result, hold ready low for a random stall, then keep it
	// high until a transfer takes place.
	initial begin : result_drain
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MaxIdle);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Moves one byte across the input channel. A random gap with valid low comes
	// first; with no gap, valid stays high and the next payload follows directly.
	// The byte goes to the parser copy at the edge of its transfer.
	task automatic send_item(input logic start, input logic [ByteW-1:0] b);
		int unsigned gap;
		gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start <= start;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		if (!book.take_byte(start, b))
			parsed_bytes++;
	endtask

	task automatic send_random_byte(input logic start);
		send_item(start, ByteW'($urandom));
	endtask

	// One random stretch of stimulus. Most of it is a well-formed masked text frame
	// with random content, sometimes cut short so the next frame start lands in
	// the middle of it. The rest is broken headers and loose noise bytes.
	task automatic send_random_frame();
		int unsigned sel;
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		int unsigned key_cut;
		bit          ext;
		logic [ByteW-1:0] b;
		sel = $urandom_range(0, 99);
		no_idle = ($urandom_range(0, 6) == 0);
		if (sel < 80) begin
			// Opcode nibble forced to text; FIN and RSV bits stay random.
			b = ByteW'($urandom);
			b[3:0] = OpText;
			send_item(1'b1, b);
			pick = $urandom_range(0, 99);
			ext = (pick >= 70);
			if (pick < 55)
				len = $urandom_range(0, 12);
			else if (pick < 70)
				len = $urandom_range(0, 125);
			else if (pick < 90)
				len = $urandom_range(0, 40);
			else if (pick < 96)
				len = $urandom_range(126, 400);
			else
				len = $urandom_range(0, 65535);
			if (ext) begin
				send_item(1'b0, {1'b1, Len7Ext16});
				send_item(1'b0, len[15:8]);
				send_item(1'b0, len[7:0]);
			end else begin
				send_item(1'b0, {1'b1, len[6:0]});
			end
			// Now and then the key itself is broken off.
			key_cut = ($urandom_range(0, 24) == 0) ? $urandom_range(0, KeyBytes - 1)
				: KeyBytes;
			for (int i = 0; i < key_cut; i++)
				send_random_byte(1'b0);
			if (key_cut < KeyBytes)
				return;
			// Very long payloads are always abandoned early, which still runs the
			// upper length bits through the counter.
			if (len > 400 || $urandom_range(0, 19) == 0)
				cut = $urandom_range(0, (len < 30) ? len : 30);
			else
				cut = len;
			for (int i = 0; i < cut; i++)
				send_random_byte(1'b0);
		end else if (sel < 92) begin
			// A frame start followed by a random header and a little debris.
			send_random_byte(1'b1);
			send_random_byte(1'b0);
			pick = $urandom_range(0, 3);
			for (int i = 0; i < pick; i++)
				send_random_byte(1'b0);
		end else begin
			pick = $urandom_range(1, 6);
			for (int i = 0; i < pick; i++)
				send_random_byte($urandom_range(0, 3) == 0);
		end
	endtask

	initial begin : stimulus
		logic [8:0] directed_seq[$];
		book = new();
		// Directed bytes, written as {frame_start, data_byte}:
		// a stray byte while idle, a non-text opcode, a clear mask bit with a
		// length of 125, the 64-bit length code, an empty frame in the 16-bit
		// length form, a frame abandoned after its header by a new frame start,
		// and a one-byte payload whose key byte of all ones unmasks it to zero.
		directed_seq = '{
			9'h05A,
			9'h100,
			9'h181, 9'h07D,
			9'h101, 9'h0FF,
			9'h171, 9'h0FE, 9'h000, 9'h000, 9'h000, 9'h0FF, 9'h03C, 9'h0C3,
			9'h181, 9'h085,
			9'h1F1, 9'h081, 9'h0FF, 9'h011, 9'h022, 9'h033, 9'h0FF
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_seq[i])
			send_item(directed_seq[i][8], directed_seq[i][7:0]);
		while (parsed_bytes < ByteTarget)
			send_random_frame();
		in_valid <= 1'b0;
		// Drain every pending result, then leave room for anything stray to surface,
		// including a full receiver stall on top of the pipeline latency.
		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (book.mismatches == 0)
			$display("tb_websocket_text_frame_unmasker_core: clean");
		else
			$display("tb_websocket_text_frame_unmasker_core: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/wsu_pkg.sv
src/wsu_parser.sv
src/wsu_out_reg.sv
src/websocket_text_frame_unmasker_core.sv
dv/tb_websocket_text_frame_unmasker_core.sv
